[sv/pidtir_pkg.sv]
// ----------------------------------------------------------------------------
// pidtir_pkg: shared types and constants for the trapezoidal-integral PID
// Widths of the fixed-point datapath, sequencer states and register indexes.
// ----------------------------------------------------------------------------
package pidtir_pkg;

    // field widths
    localparam int ERR_W   = 32;                 // error and drive, signed Q16.16
    localparam int US_W    = 20;                 // elapsed time in microseconds
    localparam int INT_W   = 48;                 // integral, signed Q32.16
    localparam int GAIN_W  = 32;                 // unsigned Q16.16 gains
    localparam int WIND_W  = 31;                 // windup range
    localparam int FRAC_W  = 16;                 // fraction bits of the gains
    localparam int TDATA_W = 56;                 // error + elapsed, padded to bytes
    localparam int TUSER_W = 4;
    localparam int DATA_W  = 32;                 // configuration data bus
    localparam int ADDR_W  = 5;                  // five registers at 4*i

    // datapath widths
    localparam int ABS_W   = ERR_W + 1;          // |prev + e|, |e - prev|
    localparam int PROD_W  = ABS_W + US_W;       // multiplier product / dividend
    localparam int REM_W   = 21;                 // divider remainder
    localparam int MAG_W   = 49;                 // largest term magnitude
    localparam int GPROD_W = GAIN_W + MAG_W;     // magnitude times gain
    localparam int TERM_W  = 62;                 // saturated term magnitude
    localparam int SUM_W   = 64;                 // exact sum of three terms
    localparam int CNT_W   = 6;

    // iteration counts
    localparam int MUL_STEPS  = US_W;
    localparam int DIV_STEPS  = PROD_W;
    localparam int GAIN_STEPS = MAG_W;
    localparam int SUM_STEPS  = 3;

    // tuser bit positions
    localparam int TU_RESTART = 0;
    localparam int TU_USE_P   = 1;
    localparam int TU_USE_I   = 2;
    localparam int TU_USE_D   = 3;

    // constants
    localparam logic [REM_W-1:0]  INC_DIV      = 21'd2000000;
    localparam logic [US_W-1:0]   DERIV_SCALE  = 20'd1000000;
    localparam logic [US_W-1:0]   DERIV_MIN_US = 20'd10;
    localparam logic [TERM_W-1:0] TERM_LIM     = 62'h2000_0000_0000_0000;

    // term lanes, selected by the low counter bits while summing
    localparam logic [1:0] LANE_P = 2'd0;
    localparam logic [1:0] LANE_I = 2'd1;
    localparam logic [1:0] LANE_D = 2'd2;

    typedef enum logic [2:0] {
        REG_GAIN_P,
        REG_GAIN_I,
        REG_GAIN_D,
        REG_WINDUP,
        REG_SIGN_FLIP
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_DIV,
        ST_INTEG,
        ST_LOAD,
        ST_GAIN,
        ST_SUM,
        ST_OUT
    } state_t;

endpackage

[sv/pid_trapezoid_integral_resets.sv]
// ----------------------------------------------------------------------------
// pid_trapezoid_integral_resets: PID controller with trapezoidal integral
// Bit-serial multipliers and restoring dividers compute the integral step,
// the derivative and the three gain terms; the result is a saturated Q16.16.
// ----------------------------------------------------------------------------
// One update runs through the sequencer states in order: prepare magnitudes,
// shift-add multiplication (one multiplier bit a cycle), restoring division
// (one quotient bit a cycle), update of the integral and load of the gain
// lanes, gain multiplication (one magnitude bit a cycle), accumulation of the
// terms and saturation into the output register once it is free. The block
// then takes the next item while that result waits in the output register.
// ----------------------------------------------------------------------------
module pid_trapezoid_integral_resets
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [pidtir_pkg::ADDR_W-1:0]        paddr,
    input  logic [pidtir_pkg::DATA_W-1:0]        pwdata,
    output logic [pidtir_pkg::DATA_W-1:0]        prdata,
    output logic                                 pready,
    // input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [pidtir_pkg::TDATA_W-1:0]       s_tdata,  // error_value[31:0], elapsed_us[51:32]
    input  logic [pidtir_pkg::TUSER_W-1:0]       s_tuser,  // restart[0], use_p[1], use_i[2], use_d[3]
    // output stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [pidtir_pkg::ERR_W-1:0]         m_tdata   // drive[31:0]
);

    localparam int ERR_W   = pidtir_pkg::ERR_W;
    localparam int US_W    = pidtir_pkg::US_W;
    localparam int INT_W   = pidtir_pkg::INT_W;
    localparam int GAIN_W  = pidtir_pkg::GAIN_W;
    localparam int WIND_W  = pidtir_pkg::WIND_W;
    localparam int ABS_W   = pidtir_pkg::ABS_W;
    localparam int PROD_W  = pidtir_pkg::PROD_W;
    localparam int REM_W   = pidtir_pkg::REM_W;
    localparam int MAG_W   = pidtir_pkg::MAG_W;
    localparam int GPROD_W = pidtir_pkg::GPROD_W;
    localparam int TERM_W  = pidtir_pkg::TERM_W;
    localparam int SUM_W   = pidtir_pkg::SUM_W;
    localparam int CNT_W   = pidtir_pkg::CNT_W;
    localparam int FRAC_W  = pidtir_pkg::FRAC_W;
    localparam int DATA_W  = pidtir_pkg::DATA_W;
    localparam int ADDR_W_HI = pidtir_pkg::ADDR_W - 1;

    // ------------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------------
    pidtir_pkg::state_t          state_reg, state_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;

    logic [GAIN_W-1:0]           gain_p_reg, gain_p_next;
    logic [GAIN_W-1:0]           gain_i_reg, gain_i_next;
    logic [GAIN_W-1:0]           gain_d_reg, gain_d_next;
    logic [WIND_W-1:0]           windup_reg, windup_next;
    logic                        sign_flip_reg, sign_flip_next;

    logic [ERR_W-1:0]            last_error_reg, last_error_next;
    logic [INT_W-1:0]            integral_reg, integral_next;
    logic                        have_prev_reg, have_prev_next;

    logic                        m_tvalid_reg, m_tvalid_next;
    logic [ERR_W-1:0]            m_tdata_reg, m_tdata_next;

    // per-item working registers
    logic [ERR_W-1:0]            e_reg, e_next;
    logic [ERR_W-1:0]            prev_reg, prev_next;
    logic [US_W-1:0]             us_reg, us_next;
    logic [2:0]                  use_reg, use_next;     // {d, i, p}
    logic                        s_neg_reg, s_neg_next;
    logic                        d_neg_reg, d_neg_next;
    logic                        clear_reg, clear_next;
    logic                        us_gt_reg, us_gt_next;
    logic [ABS_W-1:0]            mcand_a_reg, mcand_a_next;
    logic [ABS_W-1:0]            mcand_b_reg, mcand_b_next;
    logic [PROD_W-1:0]           lane_a_reg, lane_a_next;
    logic [PROD_W-1:0]           lane_b_reg, lane_b_next;
    logic [REM_W-1:0]            rem_a_reg, rem_a_next;
    logic [REM_W-1:0]            rem_b_reg, rem_b_next;
    logic [GPROD_W-1:0]          gp_reg, gp_next;
    logic [GPROD_W-1:0]          gi_reg, gi_next;
    logic [GPROD_W-1:0]          gd_reg, gd_next;
    logic [SUM_W-1:0]            sum_reg, sum_next;

    // ------------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------------
    logic                        s_accept;
    logic                        out_free;
    logic                        load_out;
    logic                        cfg_write;
    logic [2:0]                  cfg_idx;

    logic [ERR_W-1:0]            in_error;
    logic [US_W-1:0]             in_us;
    logic                        in_restart;

    assign in_error   = s_tdata[ERR_W-1:0];
    assign in_us      = s_tdata[ERR_W +: US_W];
    assign in_restart = s_tuser[pidtir_pkg::TU_RESTART];

    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[ADDR_W_HI:2];

    assign pready   = 1'b1;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb
    begin
        unique case (cfg_idx)
            pidtir_pkg::REG_GAIN_P:    prdata = gain_p_reg;
            pidtir_pkg::REG_GAIN_I:    prdata = gain_i_reg;
            pidtir_pkg::REG_GAIN_D:    prdata = gain_d_reg;
            pidtir_pkg::REG_WINDUP:    prdata = {{(DATA_W-WIND_W){1'b0}}, windup_reg};
            pidtir_pkg::REG_SIGN_FLIP: prdata = {{(DATA_W-1){1'b0}}, sign_flip_reg};
            default:                   prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // sequencer: next state
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            pidtir_pkg::ST_IDLE:
            begin
                if (s_accept)
                begin
                    state_next = pidtir_pkg::ST_PREP;
                end
            end
            pidtir_pkg::ST_PREP:
            begin
                state_next = pidtir_pkg::ST_MUL;
                cnt_next   = CNT_W'(pidtir_pkg::MUL_STEPS - 1);
            end
            pidtir_pkg::ST_MUL:
            begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = pidtir_pkg::ST_DIV;
                    cnt_next   = CNT_W'(pidtir_pkg::DIV_STEPS - 1);
                end
            end
            pidtir_pkg::ST_DIV:
            begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = pidtir_pkg::ST_INTEG;
                end
            end
            pidtir_pkg::ST_INTEG:
            begin
                state_next = pidtir_pkg::ST_LOAD;
            end
            pidtir_pkg::ST_LOAD:
            begin
                state_next = pidtir_pkg::ST_GAIN;
                cnt_next   = CNT_W'(pidtir_pkg::GAIN_STEPS - 1);
            end
            pidtir_pkg::ST_GAIN:
            begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = pidtir_pkg::ST_SUM;
                    cnt_next   = CNT_W'(pidtir_pkg::SUM_STEPS - 1);
                end
            end
            pidtir_pkg::ST_SUM:
            begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = pidtir_pkg::ST_OUT;
                end
            end
            pidtir_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = pidtir_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pidtir_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // sequencer: outputs
    // ------------------------------------------------------------------------
    always_comb
    begin
        s_tready = (state_reg == pidtir_pkg::ST_IDLE);
        load_out = (state_reg == pidtir_pkg::ST_OUT) && out_free;
    end

    // ------------------------------------------------------------------------
    // datapath helpers
    // ------------------------------------------------------------------------
    // prepare: sums, magnitudes and clear decision
    logic [ABS_W-1:0]   s_sum;
    logic [ABS_W-1:0]   d_diff;
    logic               sign_differs;
    logic               flip_clear;
    logic               wind_clear;

    assign s_sum  = {e_reg[ERR_W-1], e_reg} + {prev_reg[ERR_W-1], prev_reg};
    assign d_diff = {e_reg[ERR_W-1], e_reg} - {prev_reg[ERR_W-1], prev_reg};

    // zero has a sign of its own
    assign sign_differs = ((e_reg == '0) != (prev_reg == '0))
                       || (e_reg[ERR_W-1] != prev_reg[ERR_W-1]);
    assign flip_clear   = sign_flip_reg && sign_differs;
    assign wind_clear   = (windup_reg != '0)
                       && ($signed(e_reg) > $signed({1'b0, windup_reg}));

    // shift-add multiply step, multiplier bits leave at the bottom
    logic [ABS_W:0]     mul_a_sum;
    logic [ABS_W:0]     mul_b_sum;

    assign mul_a_sum = {1'b0, lane_a_reg[PROD_W-1:US_W]}
                     + (lane_a_reg[0] ? {1'b0, mcand_a_reg} : '0);
    assign mul_b_sum = {1'b0, lane_b_reg[PROD_W-1:US_W]}
                     + (lane_b_reg[0] ? {1'b0, mcand_b_reg} : '0);

    // restoring divide step, quotient bits enter at the bottom
    logic [REM_W:0]     div_a_shift;
    logic [REM_W:0]     div_b_shift;
    logic [REM_W+1:0]   div_a_diff;
    logic [REM_W+1:0]   div_b_diff;
    logic               div_a_ge;
    logic               div_b_ge;

    assign div_a_shift = {rem_a_reg, lane_a_reg[PROD_W-1]};
    assign div_b_shift = {rem_b_reg, lane_b_reg[PROD_W-1]};
    assign div_a_diff  = {1'b0, div_a_shift} - {2'b0, pidtir_pkg::INC_DIV};
    assign div_b_diff  = {1'b0, div_b_shift} - {{(REM_W+2-US_W){1'b0}}, us_reg};
    assign div_a_ge    = !div_a_diff[REM_W+1];
    assign div_b_ge    = !div_b_diff[REM_W+1];

    // integral update: base plus signed increment, saturated to 48 bits
    logic [INT_W:0]     inc_mag;
    logic [INT_W:0]     integ_sum;
    logic [INT_W-1:0]   integ_sat;

    assign inc_mag   = {{(INT_W+1-ERR_W){1'b0}}, lane_a_reg[ERR_W-1:0]};
    assign integ_sum = {integral_reg[INT_W-1], integral_reg}
                     + (s_neg_reg ? ~inc_mag : inc_mag)
                     + {{INT_W{1'b0}}, s_neg_reg};

    always_comb
    begin
        if (integ_sum[INT_W] != integ_sum[INT_W-1])
        begin
            integ_sat = integ_sum[INT_W] ? {1'b1, {(INT_W-1){1'b0}}}
                                         : {1'b0, {(INT_W-1){1'b1}}};
        end
        else
        begin
            integ_sat = integ_sum[INT_W-1:0];
        end
    end

    // gain multiply step for the three lanes
    logic [GAIN_W:0]    gp_sum;
    logic [GAIN_W:0]    gi_sum;
    logic [GAIN_W:0]    gd_sum;

    assign gp_sum = {1'b0, gp_reg[GPROD_W-1:MAG_W]} + (gp_reg[0] ? {1'b0, gain_p_reg} : '0);
    assign gi_sum = {1'b0, gi_reg[GPROD_W-1:MAG_W]} + (gi_reg[0] ? {1'b0, gain_i_reg} : '0);
    assign gd_sum = {1'b0, gd_reg[GPROD_W-1:MAG_W]} + (gd_reg[0] ? {1'b0, gain_d_reg} : '0);

    // term accumulation: one lane per cycle
    logic [GPROD_W-1:0]          term_prod;
    logic                        term_neg;
    logic                        term_en;
    logic [GPROD_W-FRAC_W-1:0]   term_mag;
    logic [TERM_W-1:0]           term_sat;
    logic [SUM_W-1:0]            term_val;

    always_comb
    begin
        unique case (cnt_reg[1:0])
            pidtir_pkg::LANE_P:
            begin
                term_prod = gp_reg;
                term_neg  = e_reg[ERR_W-1];
                term_en   = use_reg[0];
            end
            pidtir_pkg::LANE_I:
            begin
                term_prod = gi_reg;
                term_neg  = integral_reg[INT_W-1];
                term_en   = use_reg[1];
            end
            pidtir_pkg::LANE_D:
            begin
                term_prod = gd_reg;
                term_neg  = d_neg_reg;
                term_en   = use_reg[2];
            end
            default:
            begin
                term_prod = '0;
                term_neg  = 1'b0;
                term_en   = 1'b0;
            end
        endcase
    end

    assign term_mag = term_prod[GPROD_W-1:FRAC_W];
    assign term_sat = (term_mag > {{(GPROD_W-FRAC_W-TERM_W){1'b0}}, pidtir_pkg::TERM_LIM})
                    ? pidtir_pkg::TERM_LIM : term_mag[TERM_W-1:0];
    assign term_val = {{(SUM_W-TERM_W){1'b0}}, term_sat};

    // output saturation to 32 bits
    logic [ERR_W-1:0]   drive_sat;

    always_comb
    begin
        if (!sum_reg[SUM_W-1] && (|sum_reg[SUM_W-2:ERR_W-1]))
        begin
            drive_sat = {1'b0, {(ERR_W-1){1'b1}}};
        end
        else if (sum_reg[SUM_W-1] && !(&sum_reg[SUM_W-2:ERR_W-1]))
        begin
            drive_sat = {1'b1, {(ERR_W-1){1'b0}}};
        end
        else
        begin
            drive_sat = sum_reg[ERR_W-1:0];
        end
    end

    // ------------------------------------------------------------------------
    // datapath: next values
    // ------------------------------------------------------------------------
    always_comb
    begin
        gain_p_next     = gain_p_reg;
        gain_i_next     = gain_i_reg;
        gain_d_next     = gain_d_reg;
        windup_next     = windup_reg;
        sign_flip_next  = sign_flip_reg;
        last_error_next = last_error_reg;
        integral_next   = integral_reg;
        have_prev_next  = have_prev_reg;
        m_tdata_next    = m_tdata_reg;
        e_next          = e_reg;
        prev_next       = prev_reg;
        us_next         = us_reg;
        use_next        = use_reg;
        s_neg_next      = s_neg_reg;
        d_neg_next      = d_neg_reg;
        clear_next      = clear_reg;
        us_gt_next      = us_gt_reg;
        mcand_a_next    = mcand_a_reg;
        mcand_b_next    = mcand_b_reg;
        lane_a_next     = lane_a_reg;
        lane_b_next     = lane_b_reg;
        rem_a_next      = rem_a_reg;
        rem_b_next      = rem_b_reg;
        gp_next         = gp_reg;
        gi_next         = gi_reg;
        gd_next         = gd_reg;
        sum_next        = sum_reg;

        m_tvalid_next = (m_tvalid_reg && !m_tready) || load_out;

        if (cfg_write)
        begin
            unique case (cfg_idx)
                pidtir_pkg::REG_GAIN_P:    gain_p_next    = pwdata;
                pidtir_pkg::REG_GAIN_I:    gain_i_next    = pwdata;
                pidtir_pkg::REG_GAIN_D:    gain_d_next    = pwdata;
                pidtir_pkg::REG_WINDUP:    windup_next    = pwdata[WIND_W-1:0];
                pidtir_pkg::REG_SIGN_FLIP: sign_flip_next = pwdata[0];
                default:                   ;
            endcase
        end

        unique case (state_reg)
            pidtir_pkg::ST_IDLE:
            begin
                if (s_accept)
                begin
                    e_next    = in_error;
                    us_next   = in_us;
                    prev_next = (have_prev_reg && !in_restart) ? last_error_reg : in_error;
                    use_next  = {s_tuser[pidtir_pkg::TU_USE_D],
                                 s_tuser[pidtir_pkg::TU_USE_I],
                                 s_tuser[pidtir_pkg::TU_USE_P]};
                    last_error_next = in_error;
                    have_prev_next  = 1'b1;
                    if (in_restart)
                    begin
                        integral_next = '0;
                    end
                    rem_a_next = '0;
                    rem_b_next = '0;
                    sum_next   = '0;
                end
            end
            pidtir_pkg::ST_PREP:
            begin
                s_neg_next   = s_sum[ABS_W-1];
                d_neg_next   = d_diff[ABS_W-1];
                mcand_a_next = s_sum[ABS_W-1] ? (~s_sum + 1'b1) : s_sum;
                mcand_b_next = d_diff[ABS_W-1] ? (~d_diff + 1'b1) : d_diff;
                clear_next   = flip_clear || wind_clear;
                us_gt_next   = (us_reg > pidtir_pkg::DERIV_MIN_US);
                lane_a_next  = {{ABS_W{1'b0}}, us_reg};
                lane_b_next  = {{ABS_W{1'b0}}, pidtir_pkg::DERIV_SCALE};
            end
            pidtir_pkg::ST_MUL:
            begin
                lane_a_next = {mul_a_sum, lane_a_reg[US_W-1:1]};
                lane_b_next = {mul_b_sum, lane_b_reg[US_W-1:1]};
            end
            pidtir_pkg::ST_DIV:
            begin
                rem_a_next  = div_a_ge ? div_a_diff[REM_W-1:0] : div_a_shift[REM_W-1:0];
                rem_b_next  = div_b_ge ? div_b_diff[REM_W-1:0] : div_b_shift[REM_W-1:0];
                lane_a_next = {lane_a_reg[PROD_W-2:0], div_a_ge};
                lane_b_next = {lane_b_reg[PROD_W-2:0], div_b_ge};
            end
            pidtir_pkg::ST_INTEG:
            begin
                integral_next = clear_reg ? '0 : integ_sat;
            end
            pidtir_pkg::ST_LOAD:
            begin
                gp_next = {{(GPROD_W-ERR_W){1'b0}},
                           e_reg[ERR_W-1] ? (~e_reg + 1'b1) : e_reg};
                gi_next = {{(GPROD_W-INT_W){1'b0}},
                           integral_reg[INT_W-1] ? (~integral_reg + 1'b1) : integral_reg};
                gd_next = us_gt_reg ? {{GAIN_W{1'b0}}, lane_b_reg[MAG_W-1:0]} : '0;
            end
            pidtir_pkg::ST_GAIN:
            begin
                gp_next = {gp_sum, gp_reg[MAG_W-1:1]};
                gi_next = {gi_sum, gi_reg[MAG_W-1:1]};
                gd_next = {gd_sum, gd_reg[MAG_W-1:1]};
            end
            pidtir_pkg::ST_SUM:
            begin
                if (term_en)
                begin
                    // conditional negate folded into the add
                    sum_next = sum_reg + (term_neg ? ~term_val : term_val)
                             + {{(SUM_W-1){1'b0}}, term_neg};
                end
            end
            pidtir_pkg::ST_OUT:
            begin
                if (load_out)
                begin
                    m_tdata_next = drive_sat;
                end
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pidtir_pkg::ST_IDLE;
            cnt_reg        <= '0;
            gain_p_reg     <= '0;
            gain_i_reg     <= '0;
            gain_d_reg     <= '0;
            windup_reg     <= '0;
            sign_flip_reg  <= 1'b0;
            last_error_reg <= '0;
            integral_reg   <= '0;
            have_prev_reg  <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            gain_p_reg     <= gain_p_next;
            gain_i_reg     <= gain_i_next;
            gain_d_reg     <= gain_d_next;
            windup_reg     <= windup_next;
            sign_flip_reg  <= sign_flip_next;
            last_error_reg <= last_error_next;
            integral_reg   <= integral_next;
            have_prev_reg  <= have_prev_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        e_reg       <= e_next;
        prev_reg    <= prev_next;
        us_reg      <= us_next;
        use_reg     <= use_next;
        s_neg_reg   <= s_neg_next;
        d_neg_reg   <= d_neg_next;
        clear_reg   <= clear_next;
        us_gt_reg   <= us_gt_next;
        mcand_a_reg <= mcand_a_next;
        mcand_b_reg <= mcand_b_next;
        lane_a_reg  <= lane_a_next;
        lane_b_reg  <= lane_b_next;
        rem_a_reg   <= rem_a_next;
        rem_b_reg   <= rem_b_next;
        gp_reg      <= gp_next;
        gi_reg      <= gi_next;
        gd_reg      <= gd_next;
        sum_reg     <= sum_next;
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == pidtir_pkg::ST_PREP && have_prev_reg))
        else $error("input transfer did not start an update");

    a_rem_a_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pidtir_pkg::ST_DIV || state_reg == pidtir_pkg::ST_INTEG)
        |-> (rem_a_reg < pidtir_pkg::INC_DIV))
        else $error("integral divider remainder out of range");

    a_rem_b_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == pidtir_pkg::ST_DIV || state_reg == pidtir_pkg::ST_INTEG)
         && us_reg != '0)
        |-> (rem_b_reg < {{(REM_W-US_W){1'b0}}, us_reg}))
        else $error("derivative divider remainder out of range");

    a_integral_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pidtir_pkg::ST_INTEG && clear_reg) |=> (integral_reg == '0))
        else $error("integral not cleared");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == pidtir_pkg::ST_OUT))
        else $error("result raised outside the output step");
`endif

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stream-level test of the trapezoidal-integral PID controller
// Drives error samples through the input stream, programs gains and integral
// clear options over the configuration port between phases, and compares every
// drive value against a cycle-free fixed-point controller model kept here.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int ERR_W   = pidtir_pkg::ERR_W;
    localparam int US_W    = pidtir_pkg::US_W;
    localparam int GAIN_W  = pidtir_pkg::GAIN_W;
    localparam int WIND_W  = pidtir_pkg::WIND_W;
    localparam int FRAC_W  = pidtir_pkg::FRAC_W;
    localparam int ADDR_W  = pidtir_pkg::ADDR_W;
    localparam int DATA_W  = pidtir_pkg::DATA_W;
    localparam int TDATA_W = pidtir_pkg::TDATA_W;
    localparam int TUSER_W = pidtir_pkg::TUSER_W;

    typedef struct packed {
        logic [ERR_W-1:0] err;
        logic [US_W-1:0]  elapsed;
        logic             use_d;
        logic             use_i;
        logic             use_p;
        logic             restart;
    } pid_sample_t;

    // flag bits, in stream sideband order
    localparam logic [3:0] F_RESTART = 4'b0001;
    localparam logic [3:0] F_P       = 4'b0010;
    localparam logic [3:0] F_I       = 4'b0100;
    localparam logic [3:0] F_D       = 4'b1000;
    localparam logic [3:0] F_ALL     = F_P | F_I | F_D;

    localparam longint INTEG_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint INTEG_MIN = -64'sh0000_8000_0000_0000;
    localparam longint DRIVE_MAX = 64'sd2147483647;
    localparam longint DRIVE_MIN = -64'sd2147483648;
    localparam logic [127:0] TERM_CAP = 128'h1 << 61;

    localparam int PHASES     = 12;
    localparam int PHASE_LEN  = 128;
    localparam int LONG_HOLD  = 700;
    localparam int HOLD_EVERY = 600;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [ADDR_W-1:0]    paddr    = '0;
    logic [DATA_W-1:0]    pwdata   = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata  = '0;
    logic [TUSER_W-1:0]   s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [ERR_W-1:0]     m_tdata;

    // controller model state and its copy of the registers
    logic [ERR_W-1:0]     ctl_last_err  = '0;
    longint               ctl_integral  = 0;
    logic                 ctl_have_prev = 1'b0;
    logic [GAIN_W-1:0]    cfg_gain_p    = '0;
    logic [GAIN_W-1:0]    cfg_gain_i    = '0;
    logic [GAIN_W-1:0]    cfg_gain_d    = '0;
    logic [WIND_W-1:0]    cfg_windup    = '0;
    logic                 cfg_sign_flip = 1'b0;

    pid_sample_t          pending_samples[$];
    logic [ERR_W-1:0]     expected_drive[$];
    pid_sample_t          in_flight;
    logic [ERR_W-1:0]     drive_want;
    logic [ERR_W-1:0]     walk_err      = '0;
    logic                 burst_mode    = 1'b0;
    int                   gap_left      = 0;
    int                   stall_left    = 0;
    int                   hold_left     = 0;
    int                   next_hold_at  = 350;
    int                   taken_count   = 0;
    int                   fail_count    = 0;

    pid_trapezoid_integral_resets u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #30ms;
        $display("FAILURE");
        $finish;
    end

    function automatic int sign_of(longint v);
        if (v > 0)
            return 1;
        if (v < 0)
            return -1;
        return 0;
    endfunction

    // (v * g) >> 16 toward zero, magnitude capped at 2^61
    function automatic longint scale_term(longint v, logic [GAIN_W-1:0] g);
        logic [127:0] mag;
        logic [127:0] prod;
        mag  = (v < 0) ? 128'(-v) : 128'(v);
        prod = (mag * 128'(g)) >> FRAC_W;
        if (prod > TERM_CAP)
            prod = TERM_CAP;
        return (v < 0) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
    endfunction

    function automatic logic [ERR_W-1:0] predict_drive(pid_sample_t s);
        longint e;
        longint us;
        longint prev;
        longint acc;
        longint rate;
        longint total;
        e  = longint'(signed'(s.err));
        us = longint'(s.elapsed);
        if (s.restart)
        begin
            ctl_integral  = 0;
            ctl_have_prev = 1'b0;
        end
        prev = ctl_have_prev ? longint'(signed'(ctl_last_err)) : e;

        acc = ctl_integral + ((prev + e) * us) / 2000000;
        if (acc > INTEG_MAX)
            acc = INTEG_MAX;
        if (acc < INTEG_MIN)
            acc = INTEG_MIN;
        // sign change wins over windup; a step to or from zero is a change
        if (cfg_sign_flip && sign_of(e) != sign_of(prev))
            acc = 0;
        else if (cfg_windup != 0 && e > longint'(cfg_windup))
            acc = 0;
        ctl_integral = acc;

        rate = (us > 10) ? ((e - prev) * 1000000) / us : 0;

        total = 0;
        if (s.use_p)
            total += scale_term(e, cfg_gain_p);
        if (s.use_i)
            total += scale_term(ctl_integral, cfg_gain_i);
        if (s.use_d)
            total += scale_term(rate, cfg_gain_d);
        if (total > DRIVE_MAX)
            total = DRIVE_MAX;
        if (total < DRIVE_MIN)
            total = DRIVE_MIN;

        ctl_last_err  = s.err;
        ctl_have_prev = 1'b1;
        return total[ERR_W-1:0];
    endfunction

    function automatic int idle_gap();
        int r;
        if (burst_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    function automatic pid_sample_t random_sample();
        pid_sample_t s;
        case ($urandom_range(0, 9))
            0:
                s.err = $urandom();
            1:
                case ($urandom_range(0, 4))
                    0:       s.err = 32'h7FFF_FFFF;
                    1:       s.err = 32'h8000_0000;
                    2:       s.err = 32'h0000_0000;
                    3:       s.err = 32'h0000_0001;
                    default: s.err = 32'hFFFF_FFFF;
                endcase
            2, 3, 4, 5:
                s.err = walk_err + $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
            default:
                s.err = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        endcase
        walk_err = s.err;
        case ($urandom_range(0, 7))
            0:       s.elapsed = US_W'($urandom_range(0, 10));
            1:       s.elapsed = US_W'($urandom());
            2:       s.elapsed = '1;
            default: s.elapsed = US_W'($urandom_range(11, 50000));
        endcase
        s.restart = ($urandom_range(0, 19) == 0);
        s.use_p   = ($urandom_range(0, 3) != 0);
        s.use_i   = ($urandom_range(0, 3) != 0);
        s.use_d   = ($urandom_range(0, 3) != 0);
        return s;
    endfunction

    function automatic logic [GAIN_W-1:0] random_gain();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3:    return $urandom();
            default: return $urandom_range(0, 32'h0003_0000);
        endcase
    endfunction

    function automatic logic [WIND_W-1:0] random_windup();
        case ($urandom_range(0, 5))
            0, 1:    return '0;
            2:       return 31'd1;
            3:       return '1;
            4:       return WIND_W'($urandom());
            default: return WIND_W'($urandom_range(0, 32'h0008_0000));
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        fail_count++;
    endtask

    task automatic add_sample(input logic [ERR_W-1:0] err, input logic [US_W-1:0] us,
                              input logic [3:0] flags);
        pending_samples.push_back(pid_sample_t'({err, us, flags}));
    endtask

    task automatic cfg_write(input pidtir_pkg::reg_idx_t idx,
                             input logic [DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input logic [GAIN_W-1:0] gp, input logic [GAIN_W-1:0] gi,
                              input logic [GAIN_W-1:0] gd, input logic [WIND_W-1:0] wr,
                              input logic flip);
        cfg_write(pidtir_pkg::REG_GAIN_P, gp);
        cfg_write(pidtir_pkg::REG_GAIN_I, gi);
        cfg_write(pidtir_pkg::REG_GAIN_D, gd);
        cfg_write(pidtir_pkg::REG_WINDUP, {1'b0, wr});
        cfg_write(pidtir_pkg::REG_SIGN_FLIP, {31'd0, flip});
        cfg_gain_p    = gp;
        cfg_gain_i    = gi;
        cfg_gain_d    = gd;
        cfg_windup    = wr;
        cfg_sign_flip = flip;
    endtask

    // hold the sender until every queued sample has produced its drive value
    task automatic drain();
        do
            @(posedge clk);
        while (pending_samples.size() != 0 || s_tvalid || expected_drive.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_drive.push_back(predict_drive(in_flight));
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_samples.size() > 0)
                begin
                    in_flight = pending_samples.pop_front();
                    s_tdata  <= {{(TDATA_W-ERR_W-US_W){1'b0}}, in_flight.elapsed, in_flight.err};
                    s_tuser  <= {in_flight.use_d, in_flight.use_i, in_flight.use_p,
                                 in_flight.restart};
                    s_tvalid <= 1'b1;
                    gap_left = idle_gap();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // output ready: random stalls plus a long hold-off every HOLD_EVERY results
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (taken_count >= next_hold_at)
        begin
            hold_left    = LONG_HOLD;
            next_hold_at = next_hold_at + HOLD_EVERY;
            m_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (!burst_mode && $urandom_range(0, 7) == 0)
        begin
            stall_left = idle_gap();
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // output monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_drive.size() == 0)
                report_mismatch($sformatf("drive %h with nothing expected", m_tdata));
            else
            begin
                drive_want = expected_drive.pop_front();
                if (m_tdata !== drive_want)
                    report_mismatch($sformatf("drive %h, expected %h (transfer %0d)",
                                              m_tdata, drive_want, taken_count));
            end
            taken_count <= taken_count + 1;
        end
    end

    initial
    begin
        int ph;
        int n;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // registers still at reset: every term has zero gain
        add_sample(32'h0001_0000, 20'd50, F_ALL);
        add_sample(32'h8000_0000, 20'hFFFFF, F_ALL);
        drain();

        // sign-change clear on, unit gains, small derivative gain
        set_config(32'h0001_0000, 32'h0001_0000, 32'h0000_0100, 31'd0, 1'b1);
        add_sample(32'h0001_0000, 20'd1000, F_ALL | F_RESTART);
        add_sample(32'h0002_0000, 20'd11, F_ALL);
        add_sample(32'h0003_0000, 20'd10, F_ALL);
        add_sample(32'h0000_0000, 20'd0, F_ALL);
        add_sample(32'hFFFF_0000, 20'd500, F_ALL);
        add_sample(32'h7FFF_FFFF, 20'hFFFFF, F_ALL);
        add_sample(32'h8000_0000, 20'hFFFFF, F_ALL);
        add_sample(32'h8000_0000, 20'd11, F_ALL);
        add_sample(32'h7FFF_FFFF, 20'd11, F_ALL);
        add_sample(32'h0000_8000, 20'd20000, F_P | F_RESTART);
        add_sample(32'h0000_9000, 20'd20000, F_I);
        add_sample(32'h0000_A000, 20'd20000, F_D);
        add_sample(32'h0000_B000, 20'd20000, 4'b0000);
        add_sample(32'h1234_5678, 20'h55555, F_ALL);
        drain();

        // windup clear only, extreme proportional and derivative gains
        set_config(32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_FFFF, 31'h0002_0000, 1'b0);
        add_sample(32'h0001_0000, 20'd100000, F_ALL | F_RESTART);
        add_sample(32'h0002_0000, 20'd100000, F_ALL);
        add_sample(32'h0002_0001, 20'd100000, F_ALL);
        add_sample(32'hFFFF_FFFF, 20'd100000, F_ALL);
        add_sample(32'h0001_8000, 20'd100000, F_ALL);
        drain();

        // both clears armed at once
        set_config(32'h0001_0000, 32'h0001_0000, 32'h0000_0100, 31'h0002_0000, 1'b1);
        add_sample(32'hFFFF_0000, 20'd100000, F_ALL);
        add_sample(32'h0003_0000, 20'd100000, F_ALL);
        add_sample(32'h0004_0000, 20'd100000, F_ALL);
        drain();

        for (ph = 0; ph < PHASES; ph++)
        begin
            burst_mode = (ph % 4 == 3);
            if (ph == 0)
                set_config('1, '1, '1, '1, 1'b1);
            else if (ph == 1)
                set_config('0, '0, '0, '0, 1'b0);
            else
                set_config(random_gain(), random_gain(), random_gain(), random_windup(),
                           1'($urandom_range(0, 1)));
            for (n = 0; n < PHASE_LEN; n++)
                pending_samples.push_back(random_sample());
            drain();
        end

        burst_mode = 1'b0;
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
